// ===== rtl/bplb_pkg.sv =====
// Package with shared types, register indexes and reset constants of the button LED block.
package bplb_pkg;

  localparam int unsigned DebounceBits = 10;
  localparam int unsigned HoldBits     = 16;
  localparam int unsigned PeriodBits   = 16;
  localparam int unsigned CfgAddrBits  = 2;
  localparam int unsigned CfgDataBits  = 16;

  localparam logic [DebounceBits-1:0] DebounceReset   = 10'd50;
  localparam logic [HoldBits-1:0]     LongPressReset  = 16'd1500;
  localparam logic [PeriodBits-1:0]   PeriodZeroReset = 16'd500;
  localparam logic [PeriodBits-1:0]   PeriodOneReset  = 16'd1000;

  typedef enum logic [CfgAddrBits-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_PERIOD_0   = 2'd2,
    REG_PERIOD_1   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DebounceBits-1:0] debounce_ticks;
    logic [HoldBits-1:0]     long_press_ticks;
    logic [PeriodBits-1:0]   period_zero;
    logic [PeriodBits-1:0]   period_one;
  } cfg_t;

  // Button and blink control state; the elapsed counter is kept apart since its
  // width is a parameter of the top level.
  typedef struct packed {
    logic                    accepted_level;
    logic [DebounceBits-1:0] lockout_count;
    logic [HoldBits-1:0]     hold_count;
    logic                    hold_armed;
    logic                    long_flag;
    logic                    blink_enable;
    logic                    rate_flag;
    logic                    led_out;
  } ctrl_state_t;

endpackage

// ===== rtl/bplb_cfg.sv =====
// Configuration register file of the button LED block.
module bplb_cfg
  import bplb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DEBOUNCE:   cfg_d.debounce_ticks   = cfg_wdata_i[DebounceBits-1:0];
        REG_LONG_PRESS: cfg_d.long_press_ticks = cfg_wdata_i[HoldBits-1:0];
        REG_PERIOD_0:   cfg_d.period_zero      = cfg_wdata_i[PeriodBits-1:0];
        REG_PERIOD_1:   cfg_d.period_one       = cfg_wdata_i[PeriodBits-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_press_ticks <= LongPressReset;
      cfg_q.period_zero      <= PeriodZeroReset;
      cfg_q.period_one       <= PeriodOneReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bplb_step.sv =====
// Next-state logic for one tick: long-press countdown, debounce, edges and LED.
module bplb_step
  import bplb_pkg::*;
#(
  parameter int unsigned TickBits = 16
) (
  input  logic                level_i,
  input  cfg_t                cfg_i,
  input  ctrl_state_t         state_i,
  input  logic [TickBits-1:0] elapsed_i,
  output ctrl_state_t         state_o,
  output logic [TickBits-1:0] elapsed_o
);

  localparam int unsigned CmpBits = (TickBits > PeriodBits) ? TickBits : PeriodBits;

  ctrl_state_t         s;
  logic [TickBits-1:0] elapsed_inc;
  logic [PeriodBits-1:0] period;

  always_comb begin
    s = state_i;

    // Long-press countdown.
    if (s.hold_armed) begin
      if (s.hold_count != '0) begin
        s.hold_count = s.hold_count - HoldBits'(1);
      end
      if (s.hold_count == '0) begin
        s.hold_armed = 1'b0;
        if (level_i) begin
          s.long_flag = 1'b1;
        end
      end
    end

    // Debounce lockout and edge handling.
    if (s.lockout_count != '0) begin
      s.lockout_count = s.lockout_count - DebounceBits'(1);
    end else if (level_i != s.accepted_level) begin
      s.accepted_level = level_i;
      s.lockout_count  = cfg_i.debounce_ticks;
      if (level_i) begin
        s.hold_armed = 1'b1;
        s.hold_count = cfg_i.long_press_ticks;
      end else begin
        s.hold_armed = 1'b0;
        if (!s.long_flag) begin
          s.blink_enable = ~s.blink_enable;
        end else begin
          s.rate_flag = ~s.rate_flag;
          s.long_flag = 1'b0;
        end
      end
    end

    // LED: saturating elapsed count, toggle when it passes the period.
    elapsed_inc = (elapsed_i != '1) ? elapsed_i + TickBits'(1) : elapsed_i;
    period      = s.rate_flag ? cfg_i.period_one : cfg_i.period_zero;
    elapsed_o   = elapsed_inc;
    if (s.blink_enable) begin
      if (CmpBits'(elapsed_inc) > CmpBits'(period)) begin
        s.led_out = ~s.led_out;
        elapsed_o = '0;
      end
    end else begin
      s.led_out = 1'b0;
    end

    state_o = s;
  end

endmodule

// ===== rtl/button_press_led_blink_control_core.sv =====
// Top level of the debounced button, long-press and LED blink controller.
// Path: a request accepted into the input register is loaded into the result register
// when it is empty or being drained; a result that still waits holds the request back.
// Throughput: one request per cycle while the result receiver keeps up; the tick update
// is a single pass between the input register and the result register, set by the counter decrement and compare.
// Reset: asynchronous, active low; all control state clears to zero and the
// configuration registers return to 50, 1500, 500 and 1000 ticks.
module button_press_led_blink_control_core
  import bplb_pkg::*;
#(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream, one request per millisecond tick.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [0] button_level, [7:1] zero
  // Result stream, one request per tick.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [7:0]             m_axis_tdata_o,   // [0] led_level, [1] blink_on,
                                                   // [2] rate_select, [3] long_press_seen,
                                                   // [7:4] zero
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t cfg;

  bplb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register holds one tick's button level until the step logic takes it.
  logic in_valid_q, in_valid_d;
  logic in_level_q;

  // Result register; it only advances when empty or being drained. A result that
  // waits on a stalled receiver holds the tick in the input register, and the input
  // side stops accepting once both registers are full.
  logic       out_valid_q, out_valid_d;
  logic [3:0] out_data_q, out_data_d;

  ctrl_state_t                state_q, state_d;
  logic [TICK_COUNT_BITS-1:0] elapsed_q, elapsed_d;
  logic                       advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  bplb_step #(
    .TickBits (TICK_COUNT_BITS)
  ) u_step (
    .level_i   (in_level_q),
    .cfg_i     (cfg),
    .state_i   (state_q),
    .elapsed_i (elapsed_q),
    .state_o   (state_d),
    .elapsed_o (elapsed_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    out_data_d = {state_d.long_flag, state_d.rate_flag, state_d.blink_enable,
                  state_d.led_out};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      elapsed_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q   <= state_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_level_q <= s_axis_tdata_i[0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};

  // A long press can only be recorded while the button is taken as held.
  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.long_flag |-> state_q.accepted_level)
    else $error("long flag set while button is released");

  // The countdown is armed only between a press and its release.
  a_armed_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_armed |-> state_q.accepted_level)
    else $error("long-press countdown armed while button is released");

  // Tick state moves only when a tick passes into the result register.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(state_q) && $stable(elapsed_q)))
    else $error("tick state changed without a tick");

  // The LED is dark in any result with blinking off.
  a_led_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[1]) |-> !out_data_q[0])
    else $error("LED lit while blinking is off");

endmodule
